// ----- hdl/rv64i_instruction_decoder_top_defines.svh -----
// assertion macros for the rv64i instruction decoder
// used by rv64i_instruction_decoder_top; no other dependencies
`ifndef RV64I_INSTRUCTION_DECODER_TOP_DEFINES_SVH
`define RV64I_INSTRUCTION_DECODER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RV64ID_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RV64ID_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rv64id_pkg.sv -----
// shared types and constants for the rv64i instruction decoder
// no dependencies; imported by rv64i_instruction_decoder_top
package rv64id_pkg;

    // width of the running instruction address
    localparam int ADDR_W = 32;

    // major opcodes
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    // funct3 values used by name
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // mnemonic codes
    typedef enum logic [5:0] {
        MN_NONE  = 6'd0,
        MN_ADD   = 6'd1,
        MN_XOR   = 6'd2,
        MN_OR    = 6'd3,
        MN_AND   = 6'd4,
        MN_SLL   = 6'd5,
        MN_SRL   = 6'd6,
        MN_SLT   = 6'd7,
        MN_SLTU  = 6'd8,
        MN_SUB   = 6'd9,
        MN_SRA   = 6'd10,
        MN_ADDI  = 6'd11,
        MN_XORI  = 6'd12,
        MN_ORI   = 6'd13,
        MN_ANDI  = 6'd14,
        MN_SLLI  = 6'd15,
        MN_SRLI  = 6'd16,
        MN_SRAI  = 6'd17,
        MN_SLTI  = 6'd18,
        MN_SLTIU = 6'd19,
        MN_LB    = 6'd20,
        MN_LH    = 6'd21,
        MN_LW    = 6'd22,
        MN_LD    = 6'd23,
        MN_LBU   = 6'd24,
        MN_LHU   = 6'd25,
        MN_LWU   = 6'd26,
        MN_JALR  = 6'd27,
        MN_SB    = 6'd28,
        MN_SH    = 6'd29,
        MN_SW    = 6'd30,
        MN_SD    = 6'd31,
        MN_BEQ   = 6'd32,
        MN_BNE   = 6'd33,
        MN_BLT   = 6'd34,
        MN_BGE   = 6'd35,
        MN_BLTU  = 6'd36,
        MN_BGEU  = 6'd37,
        MN_JAL   = 6'd38,
        MN_LUI   = 6'd39
    } t_mnemonic;

    // instruction format classes
    typedef enum logic [2:0] {
        FMT_NONE = 3'd0,
        FMT_R    = 3'd1,
        FMT_I    = 3'd2,
        FMT_S    = 3'd3,
        FMT_B    = 3'd4,
        FMT_J    = 3'd5,
        FMT_U    = 3'd6
    } t_format;

endpackage

// ----- hdl/rv64i_instruction_decoder_top.sv -----
// Pipeline: two register stages, the input stage and then the result stage.
// Throughput: one instruction word per cycle while the output is not stalled; the two
// register stages each pass one word per cycle, and an empty input stage takes a word while a result waits downstream.
// Reset (synchronous, active low) empties both stages and sets the address to 0.
// Depends on rv64id_pkg and rv64i_instruction_decoder_top_defines.svh.
`include "rv64i_instruction_decoder_top_defines.svh"

module rv64i_instruction_decoder_top
    import rv64id_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // instruction stream in
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [31:0]  i_s_axis_tdata,   // [31:0] instruction_word
    // decoded stream out
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [5:0] mnemonic, [8:6] format_class, [13:9] dest_reg, [18:14] src1_reg,
    // [23:19] src2_reg, [44:24] immediate, [76:45] item_address,
    // [108:77] jump_target, [109] has_target, [111:110] zero
    output logic [111:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // [0] is_valid
);

    localparam int SUM_W = ADDR_W + 22;

    typedef struct packed {
        logic               has_target;
        logic [31:0]        jump_target;
        logic [31:0]        item_address;
        logic signed [20:0] immediate;
        logic [4:0]         src2_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         dest_reg;
        t_format            format_class;
        t_mnemonic          mnemonic;
    } t_result;

    logic              r_in_valid;
    logic [31:0]       r_in_word;
    logic [ADDR_W-1:0] r_in_addr;
    logic [ADDR_W-1:0] r_addr;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_out_is_valid;

    logic in_accept;
    logic advance;

    // handshake: result stage frees when empty or being taken
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_addr      <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
                r_addr     <= r_addr + ADDR_W'(4);
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input stage payload: word and its address
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_s_axis_tdata;
            r_in_addr <= r_addr;
        end
    end

    // field split
    logic [6:0] opcode;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] rd;
    logic [4:0] rs1;
    logic [4:0] rs2;

    assign opcode = r_in_word[6:0];
    assign f3     = r_in_word[14:12];
    assign f7     = r_in_word[31:25];
    assign rd     = r_in_word[11:7];
    assign rs1    = r_in_word[19:15];
    assign rs2    = r_in_word[24:20];

    // decode
    t_mnemonic          mn;
    t_format            fmt;
    logic signed [20:0] imm;
    logic               use_rd;
    logic               use_rs1;
    logic               use_rs2;

    always_comb begin
        mn      = MN_NONE;
        fmt     = FMT_NONE;
        imm     = '0;
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        unique case (opcode)
            OPC_OP: begin
                fmt     = FMT_R;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                if (f7 == F7_BASE) begin
                    unique case (f3)
                        F3_0:    mn = MN_ADD;
                        F3_1:    mn = MN_SLL;
                        F3_2:    mn = MN_SLT;
                        F3_3:    mn = MN_SLTU;
                        F3_4:    mn = MN_XOR;
                        F3_5:    mn = MN_SRL;
                        F3_6:    mn = MN_OR;
                        default: mn = MN_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_0) begin
                        mn = MN_SUB;
                    end else if (f3 == F3_5) begin
                        mn = MN_SRA;
                    end
                end
            end
            OPC_OP_IMM: begin
                fmt     = FMT_I;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                imm     = {{9{r_in_word[31]}}, r_in_word[31:20]};
                unique case (f3)
                    F3_0: mn = MN_ADDI;
                    F3_1: begin
                        mn  = MN_SLLI;
                        imm = {15'b0, r_in_word[25:20]};
                    end
                    F3_2: mn = MN_SLTI;
                    F3_3: mn = MN_SLTIU;
                    F3_4: mn = MN_XORI;
                    F3_5: begin
                        // srai whenever any of the upper six bits is set
                        mn  = (r_in_word[31:26] != 6'b0) ? MN_SRAI : MN_SRLI;
                        imm = {15'b0, r_in_word[25:20]};
                    end
                    F3_6:    mn = MN_ORI;
                    default: mn = MN_ANDI;
                endcase
            end
            OPC_LOAD: begin
                fmt     = FMT_I;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                imm     = {{9{r_in_word[31]}}, r_in_word[31:20]};
                unique case (f3)
                    F3_0:    mn = MN_LB;
                    F3_1:    mn = MN_LH;
                    F3_2:    mn = MN_LW;
                    F3_3:    mn = MN_LD;
                    F3_4:    mn = MN_LBU;
                    F3_5:    mn = MN_LHU;
                    F3_6:    mn = MN_LWU;
                    default: mn = MN_NONE;
                endcase
            end
            OPC_JALR: begin
                fmt     = FMT_I;
                use_rd  = 1'b1;
                use_rs1 = 1'b1;
                imm     = {{9{r_in_word[31]}}, r_in_word[31:20]};
                mn      = (f3 == F3_0) ? MN_JALR : MN_NONE;
            end
            OPC_STORE: begin
                fmt     = FMT_S;
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                imm     = {{9{r_in_word[31]}}, r_in_word[31:25], r_in_word[11:7]};
                unique case (f3)
                    F3_0:    mn = MN_SB;
                    F3_1:    mn = MN_SH;
                    F3_2:    mn = MN_SW;
                    F3_3:    mn = MN_SD;
                    default: mn = MN_NONE;
                endcase
            end
            OPC_BRANCH: begin
                fmt     = FMT_B;
                use_rs1 = 1'b1;
                use_rs2 = 1'b1;
                imm     = {{8{r_in_word[31]}}, r_in_word[31], r_in_word[7],
                           r_in_word[30:25], r_in_word[11:8], 1'b0};
                unique case (f3)
                    F3_0:    mn = MN_BEQ;
                    F3_1:    mn = MN_BNE;
                    F3_4:    mn = MN_BLT;
                    F3_5:    mn = MN_BGE;
                    F3_6:    mn = MN_BLTU;
                    F3_7:    mn = MN_BGEU;
                    default: mn = MN_NONE;
                endcase
            end
            OPC_JAL: begin
                fmt    = FMT_J;
                use_rd = 1'b1;
                mn     = MN_JAL;
                imm    = {r_in_word[31], r_in_word[19:12], r_in_word[20],
                          r_in_word[30:21], 1'b0};
            end
            OPC_LUI: begin
                fmt    = FMT_U;
                use_rd = 1'b1;
                mn     = MN_LUI;
                imm    = {1'b0, r_in_word[31:12]};
            end
            default: begin
                mn = MN_NONE;
            end
        endcase
        // unsupported words clear everything but the address
        if (mn == MN_NONE) begin
            fmt     = FMT_NONE;
            imm     = '0;
            use_rd  = 1'b0;
            use_rs1 = 1'b0;
            use_rs2 = 1'b0;
        end
    end

    // target address and sign of address plus offset
    logic [SUM_W-1:0]  addr_ext;
    logic [SUM_W-1:0]  imm_ext;
    logic [SUM_W-1:0]  sum;
    logic [ADDR_W+31:0] addr_pad;
    logic [ADDR_W+31:0] target_pad;
    logic              is_ctl;

    assign addr_ext   = {22'b0, r_in_addr};
    assign imm_ext    = {{(SUM_W-21){imm[20]}}, imm};
    assign sum        = addr_ext + imm_ext;
    assign addr_pad   = {32'b0, r_in_addr};
    assign target_pad = {32'b0, sum[ADDR_W-1:0]};
    assign is_ctl     = (fmt == FMT_B) || (fmt == FMT_J);

    t_result n_out;

    always_comb begin
        n_out.mnemonic     = mn;
        n_out.format_class = fmt;
        n_out.dest_reg     = use_rd  ? rd  : 5'b0;
        n_out.src1_reg     = use_rs1 ? rs1 : 5'b0;
        n_out.src2_reg     = use_rs2 ? rs2 : 5'b0;
        n_out.immediate    = imm;
        n_out.item_address = addr_pad[31:0];
        n_out.jump_target  = is_ctl ? target_pad[31:0] : 32'b0;
        n_out.has_target   = is_ctl && !sum[SUM_W-1];
    end

    // result stage payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out          <= n_out;
            r_out_is_valid <= (mn != MN_NONE);
        end
    end

    // output packing
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_is_valid;
    assign o_m_axis_tdata  = {2'b0, r_out.has_target, r_out.jump_target,
                              r_out.item_address, r_out.immediate, r_out.src2_reg,
                              r_out.src1_reg, r_out.dest_reg, r_out.format_class,
                              r_out.mnemonic};

    // checks
    `RV64ID_ASSERT_NXT(a_addr_step, i_clk, i_rst_n, in_accept,
        r_addr == $past(r_addr) + ADDR_W'(4), "address did not advance by 4")
    `RV64ID_ASSERT_IMP(a_valid_code, i_clk, i_rst_n, r_out_valid,
        r_out_is_valid == (r_out.mnemonic != MN_NONE), "valid flag disagrees with mnemonic")
    `RV64ID_ASSERT_IMP(a_invalid_clear, i_clk, i_rst_n, r_out_valid && !r_out_is_valid,
        (r_out.format_class == FMT_NONE) && (r_out.immediate == '0) && !r_out.has_target,
        "unsupported word left decode fields set")
    `RV64ID_ASSERT_IMP(a_target_fmt, i_clk, i_rst_n, r_out_valid && r_out.has_target,
        (r_out.format_class == FMT_B) || (r_out.format_class == FMT_J),
        "target flagged on a non-control instruction")

endmodule

// ----- tb/rv64id_decode_checker.sv -----
// result checker for the rv64i instruction decoder testbench
// watches both stream channels, predicts each decoded word and compares it
// depends on rv64id_pkg for the mnemonic and format codes and the opcodes
`timescale 1ns / 1ps

module rv64id_decode_checker
    import rv64id_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_tvalid,
    input  logic         i_in_tready,
    input  logic [31:0]  i_in_tdata,    // [31:0] instruction_word
    input  logic         i_out_tvalid,
    input  logic         i_out_tready,
    // [5:0] mnemonic, [8:6] format_class, [13:9] dest_reg, [18:14] src1_reg,
    // [23:19] src2_reg, [44:24] immediate, [76:45] item_address,
    // [108:77] jump_target, [109] has_target, [111:110] zero
    input  logic [111:0] i_out_tdata,
    input  logic         i_out_tuser,   // [0] is_valid
    output int           o_fail_count,
    output int           o_pending
);

    // one decoded instruction, field by field
    typedef struct packed {
        logic        valid;
        t_mnemonic   mn;
        t_format     fmt;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [20:0] imm;
        logic [31:0] addr;
        logic [31:0] target;
        logic        has_target;
    } t_decoded;

    t_decoded          decoded_q[$];
    logic [ADDR_W-1:0] pc_next;
    int                fail_total = 0;
    int                n_checked  = 0;
    int                pend_count = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pend_count;

    // expected decode of one word at a given instruction address
    function automatic t_decoded decode_word(input logic [31:0] w,
                                             input logic [ADDR_W-1:0] pc);
        t_decoded           d;
        logic [6:0]         opc;
        logic [2:0]         f3;
        logic [6:0]         f7;
        logic signed [63:0] imm;
        logic signed [63:0] sum;
        logic               use_rd, use_rs1, use_rs2;
        d       = '0;
        d.mn    = MN_NONE;
        d.fmt   = FMT_NONE;
        opc     = w[6:0];
        f3      = w[14:12];
        f7      = w[31:25];
        imm     = '0;
        use_rd  = 1'b0;
        use_rs1 = 1'b0;
        use_rs2 = 1'b0;
        case (opc)
            OPC_OP: begin
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_0: d.mn = MN_ADD;
                        F3_1: d.mn = MN_SLL;
                        F3_2: d.mn = MN_SLT;
                        F3_3: d.mn = MN_SLTU;
                        F3_4: d.mn = MN_XOR;
                        F3_5: d.mn = MN_SRL;
                        F3_6: d.mn = MN_OR;
                        default: d.mn = MN_AND;
                    endcase
                end else if (f7 == F7_ALT) begin
                    if (f3 == F3_0)      d.mn = MN_SUB;
                    else if (f3 == F3_5) d.mn = MN_SRA;
                end
                d.fmt = FMT_R;
                {use_rd, use_rs1, use_rs2} = 3'b111;
            end
            OPC_OP_IMM: begin
                case (f3)
                    F3_0: d.mn = MN_ADDI;
                    F3_1: d.mn = MN_SLLI;
                    F3_2: d.mn = MN_SLTI;
                    F3_3: d.mn = MN_SLTIU;
                    F3_4: d.mn = MN_XORI;
                    F3_5: d.mn = (w[31:26] == '0) ? MN_SRLI : MN_SRAI;
                    F3_6: d.mn = MN_ORI;
                    default: d.mn = MN_ANDI;
                endcase
                // shifts carry the 6-bit shift amount, all others a signed imm
                if (f3 == F3_1 || f3 == F3_5) imm = {58'd0, w[25:20]};
                else                          imm = $signed(w[31:20]);
                d.fmt = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_LOAD: begin
                case (f3)
                    F3_0: d.mn = MN_LB;
                    F3_1: d.mn = MN_LH;
                    F3_2: d.mn = MN_LW;
                    F3_3: d.mn = MN_LD;
                    F3_4: d.mn = MN_LBU;
                    F3_5: d.mn = MN_LHU;
                    F3_6: d.mn = MN_LWU;
                    default: d.mn = MN_NONE;
                endcase
                imm   = $signed(w[31:20]);
                d.fmt = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_JALR: begin
                d.mn  = (f3 == F3_0) ? MN_JALR : MN_NONE;
                imm   = $signed(w[31:20]);
                d.fmt = FMT_I;
                {use_rd, use_rs1} = 2'b11;
            end
            OPC_STORE: begin
                case (f3)
                    F3_0: d.mn = MN_SB;
                    F3_1: d.mn = MN_SH;
                    F3_2: d.mn = MN_SW;
                    F3_3: d.mn = MN_SD;
                    default: d.mn = MN_NONE;
                endcase
                imm   = $signed({w[31:25], w[11:7]});
                d.fmt = FMT_S;
                {use_rs1, use_rs2} = 2'b11;
            end
            OPC_BRANCH: begin
                case (f3)
                    F3_0: d.mn = MN_BEQ;
                    F3_1: d.mn = MN_BNE;
                    F3_4: d.mn = MN_BLT;
                    F3_5: d.mn = MN_BGE;
                    F3_6: d.mn = MN_BLTU;
                    F3_7: d.mn = MN_BGEU;
                    default: d.mn = MN_NONE;
                endcase
                imm   = $signed({w[31], w[7], w[30:25], w[11:8], 1'b0});
                d.fmt = FMT_B;
                {use_rs1, use_rs2} = 2'b11;
            end
            OPC_JAL: begin
                d.mn   = MN_JAL;
                imm    = $signed({w[31], w[19:12], w[20], w[30:21], 1'b0});
                d.fmt  = FMT_J;
                use_rd = 1'b1;
            end
            OPC_LUI: begin
                d.mn   = MN_LUI;
                imm    = {44'd0, w[31:12]};
                d.fmt  = FMT_U;
                use_rd = 1'b1;
            end
            default: d.mn = MN_NONE;
        endcase

        // unsupported word: everything but the address is cleared
        if (d.mn == MN_NONE) begin
            d.fmt = FMT_NONE;
            imm   = '0;
            {use_rd, use_rs1, use_rs2} = 3'b000;
        end else if (d.fmt == FMT_B || d.fmt == FMT_J) begin
            sum          = $signed({{(64 - ADDR_W){1'b0}}, pc}) + imm;
            d.target     = sum[31:0];
            d.has_target = (sum >= 0);
        end

        d.valid = (d.mn != MN_NONE);
        d.rd    = use_rd  ? w[11:7]  : 5'd0;
        d.rs1   = use_rs1 ? w[19:15] : 5'd0;
        d.rs2   = use_rs2 ? w[24:20] : 5'd0;
        d.imm   = imm[20:0];
        d.addr  = pc[31:0];
        return d;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_total++;
        $display("[%0t] decode mismatch, result %0d, %s: got %0h, expected %0h",
                 $time, n_checked, field, got, want);
    endtask

    task automatic check_field(input string field, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) report_mismatch(field, got, want);
    endtask

    // track accepted words and compare each decoded transaction in order
    always @(posedge i_clk) begin
        t_decoded got, want;
        if (!i_rst_n) begin
            pc_next = '0;
            decoded_q.delete();
            pend_count <= 0;
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                decoded_q = {decoded_q, decode_word(i_in_tdata, pc_next)};
                pc_next = pc_next + ADDR_W'(4);
            end
            if (i_out_tvalid && i_out_tready) begin
                got.valid      = i_out_tuser;
                got.mn         = t_mnemonic'(i_out_tdata[5:0]);
                got.fmt        = t_format'(i_out_tdata[8:6]);
                got.rd         = i_out_tdata[13:9];
                got.rs1        = i_out_tdata[18:14];
                got.rs2        = i_out_tdata[23:19];
                got.imm        = i_out_tdata[44:24];
                got.addr       = i_out_tdata[76:45];
                got.target     = i_out_tdata[108:77];
                got.has_target = i_out_tdata[109];
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing pending", i_out_tdata[63:0], '0);
                end else begin
                    want = decoded_q.pop_front();
                    check_field("is_valid",     got.valid,      want.valid);
                    check_field("mnemonic",     got.mn,         want.mn);
                    check_field("format_class", got.fmt,        want.fmt);
                    check_field("dest_reg",     got.rd,         want.rd);
                    check_field("src1_reg",     got.rs1,        want.rs1);
                    check_field("src2_reg",     got.rs2,        want.rs2);
                    check_field("immediate",    got.imm,        want.imm);
                    check_field("item_address", got.addr,       want.addr);
                    check_field("jump_target",  got.target,     want.target);
                    check_field("has_target",   got.has_target, want.has_target);
                end
                n_checked++;
            end
            pend_count <= decoded_q.size();
        end
    end

endmodule

// ----- tb/tb_rv64i_instruction_decoder_top.sv -----
// top of the rv64i instruction decoder testbench: clock, reset, stimulus, verdict
// drives directed and random instruction words with random gaps and stalls
// depends on rv64id_pkg, rv64i_instruction_decoder_top and rv64id_decode_checker
`timescale 1ns / 1ps

module tb_rv64i_instruction_decoder_top;
    import rv64id_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 750;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;    // [31:0] instruction_word
    logic         m_tvalid;
    logic         m_tready;
    // [5:0] mnemonic, [8:6] format_class, [13:9] dest_reg, [18:14] src1_reg,
    // [23:19] src2_reg, [44:24] immediate, [76:45] item_address,
    // [108:77] jump_target, [109] has_target, [111:110] zero
    logic [111:0] m_tdata;
    logic         m_tuser;    // [0] is_valid
    int           fail_count;
    int           pending;
    int           n_sent = 0;
    int           n_rx   = 0;

    rv64i_instruction_decoder_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    rv64id_decode_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_tvalid  (s_tvalid),
        .i_in_tready  (s_tready),
        .i_in_tdata   (s_tdata),
        .i_out_tvalid (m_tvalid),
        .i_out_tready (m_tready),
        .i_out_tdata  (m_tdata),
        .i_out_tuser  (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // instruction encoders
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [11:0] imm,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // mostly well-formed words with random fields, the rest raw noise
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom;
        if ($urandom_range(0, 99) < 88) begin
            case ($urandom_range(0, 7))
                0: begin
                    w[6:0] = OPC_OP;
                    if ($urandom_range(0, 9) != 0)
                        w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
                end
                1: begin
                    w[6:0] = OPC_OP_IMM;
                    if (w[14:12] == F3_5 && $urandom_range(0, 1)) w[31:26] = '0;
                end
                2: w[6:0] = OPC_LOAD;
                3: begin
                    w[6:0] = OPC_JALR;
                    if ($urandom_range(0, 4) != 0) w[14:12] = F3_0;
                end
                4: w[6:0] = OPC_STORE;
                5: w[6:0] = OPC_BRANCH;
                6: w[6:0] = OPC_JAL;
                default: w[6:0] = OPC_LUI;
            endcase
        end
        return w;
    endfunction

    // offer one word after a random gap, return once it is accepted
    task automatic send_word(input logic [31:0] word);
        int gap;
        gap = ((n_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    // result sink: random stalls per transaction, one long hold-off
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        m_tready <= 1'b1;
        forever begin
            do @(posedge clk); while (!(m_tvalid && m_tready));
            n_rx++;
            stall = ((n_rx / 48) % 3 == 1) ? 0 : $urandom_range(0, 14);
            // long back-pressure so the pipeline fills and stalls its input
            if (n_rx == 100) stall = 150;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // reset, stimulus and verdict
    initial begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, unsupported encodings, shift and target cases
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(enc_r(F7_BASE, 5'd0, 5'd0, F3_0, 5'd0));
        send_word(enc_r(F7_ALT, 5'd31, 5'd31, F3_0, 5'd31));
        send_word(enc_r(F7_ALT, 5'd17, 5'd9, F3_5, 5'd1));
        send_word(enc_r(7'h01, 5'd2, 5'd3, F3_0, 5'd4));
        send_word(enc_r(F7_ALT, 5'd2, 5'd3, F3_1, 5'd4));
        // slli with all upper bits set, srli/srai split on bits 31..26
        send_word(enc_i(OPC_OP_IMM, 12'hFFF, 5'd3, F3_1, 5'd4));
        send_word(enc_i(OPC_OP_IMM, 12'h03F, 5'd5, F3_5, 5'd6));
        send_word(enc_i(OPC_OP_IMM, 12'h400, 5'd7, F3_5, 5'd8));
        send_word(enc_i(OPC_OP_IMM, 12'h07F, 5'd9, F3_5, 5'd10));
        send_word(enc_i(OPC_OP_IMM, 12'h800, 5'd31, F3_0, 5'd31));
        send_word(enc_i(OPC_OP_IMM, 12'h7FF, 5'd1, F3_0, 5'd2));
        // unsigned variants still sign-extend
        send_word(enc_i(OPC_OP_IMM, 12'hFFF, 5'd1, F3_3, 5'd2));
        send_word(enc_i(OPC_LOAD, 12'hFFF, 5'd11, F3_6, 5'd12));
        send_word(enc_i(OPC_LOAD, 12'h123, 5'd11, F3_7, 5'd12));
        send_word(enc_i(OPC_JALR, 12'h800, 5'd13, F3_0, 5'd14));
        send_word(enc_i(OPC_JALR, 12'h001, 5'd13, F3_1, 5'd14));
        send_word(enc_s(12'h800, 5'd31, 5'd30, F3_3));
        send_word(enc_s(12'h7FF, 5'd1, 5'd2, F3_4));
        // branch targets: negative, far forward, exactly zero
        send_word(enc_b(13'h1000, 5'd3, 5'd4, F3_0));
        send_word(enc_b(13'h0FFE, 5'd5, 5'd6, F3_7));
        send_word(enc_b(13'h0010, 5'd5, 5'd6, F3_2));
        send_word(enc_b(13'(-4 * n_sent), 5'd7, 5'd8, F3_6));
        send_word(enc_j(21'h100000, 5'd31));
        send_word(enc_j(21'h0FFFFE, 5'd1));
        send_word({20'hFFFFF, 5'd31, OPC_LUI});

        // random traffic
        repeat (N_RANDOM) send_word(random_word());
        s_tvalid <= 1'b0;

        // drain, then allow for stray results
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- rv64i_instruction_decoder_top.f -----
+incdir+hdl
hdl/rv64id_pkg.sv
hdl/rv64i_instruction_decoder_top.sv
tb/rv64id_decode_checker.sv
tb/tb_rv64i_instruction_decoder_top.sv
